>>> hdl/joystick_differential_drive_mixer_top_defines.svh
// Assertion macros used by the joystick mixer output stage.
`ifndef JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_TOP_DEFINES_SVH
`define JOYSTICK_DIFFERENTIAL_DRIVE_MIXER_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define JDDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define JDDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define JDDM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define JDDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/jddm_pkg.sv
// Types and constants of the joystick differential drive mixer.
package jddm_pkg;

	localparam int ADC_BITS   = 10;
	localparam int CFG_W      = 10;
	localparam int SCALE_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int MAG_W      = 8;
	localparam int BYTE_W     = 8;
	localparam int CMD_W      = 6;
	localparam int PROD_W     = MAG_W + SCALE_W;
	localparam int CLAMP_W    = ((ADC_BITS > 12) ? ADC_BITS : 12) + 2;

	localparam int GAIN_DIV   = 200;
	localparam int CMD_LIMIT  = 63;
	localparam int SAT_LIMIT  = (CMD_LIMIT + 1) * GAIN_DIV;
	localparam int SAT_W      = $clog2(SAT_LIMIT);
	localparam int RECIP_W    = 13;
	localparam int GAIN_SHIFT = 20;
	localparam logic [RECIP_W-1:0] GAIN_RECIP = 13'd5243;

	localparam logic [BYTE_W-1:0] BYTE_STOP  = 8'd0;
	localparam logic [BYTE_W-1:0] LEFT_BASE  = 8'd64;
	localparam logic [BYTE_W-1:0] RIGHT_BASE = 8'd192;

	localparam logic [CFG_W-1:0]   CENTER_RST = 10'd450;
	localparam logic [CFG_W-1:0]   GAP_RST    = 10'd50;
	localparam logic [CFG_W-1:0]   TRAVEL_RST = 10'd400;
	localparam logic [SCALE_W-1:0] SCALE_RST  = 8'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERT_CENTER    = 3'd0,
		CFG_HORIZ_CENTER   = 3'd1,
		CFG_VERT_DEAD_GAP  = 3'd2,
		CFG_HORIZ_DEAD_GAP = 3'd3,
		CFG_VERT_TRAVEL    = 3'd4,
		CFG_HORIZ_TRAVEL   = 3'd5,
		CFG_SPEED_SCALE    = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] center;
		logic [CFG_W-1:0] gap;
		logic [CFG_W-1:0] travel;
	} axis_cfg_t;

	typedef struct packed {
		axis_cfg_t          vert;
		axis_cfg_t          horiz;
		logic [SCALE_W-1:0] speed_scale;
	} cfg_t;

	typedef struct packed {
		logic [ADC_BITS-1:0] vert_sample;
		logic [ADC_BITS-1:0] horiz_sample;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0] motor_byte;
		logic              last_byte;
	} out_t;

	typedef struct packed {
		logic [BYTE_W-1:0] byte_l;
		logic [BYTE_W-1:0] byte_r;
		logic              stop;
	} item_t;

endpackage

>>> hdl/jddm_axis.sv
// One joystick axis: range clamp (stage 1), dead zone and divide by four (stage 2).
module jddm_axis (
	input  logic                            clk,
	input  logic                            en,
	input  logic [jddm_pkg::ADC_BITS-1:0]   sample,
	input  jddm_pkg::axis_cfg_t             cfg,
	output logic [jddm_pkg::MAG_W-1:0]      mag,
	output logic                            above
);

	localparam int CW = jddm_pkg::CLAMP_W;
	localparam int AW = jddm_pkg::ADC_BITS;
	localparam int FW = jddm_pkg::CFG_W;
	localparam int MW = jddm_pkg::MAG_W;

	logic signed [CW-1:0] smp, ctr, gap, trv;
	logic signed [CW-1:0] lo, hi, x_c;
	logic signed [CW-1:0] inner_hi, inner_lo, diff_hi, diff_lo;
	logic signed [CW-1:0] x_s1;
	logic [MW-1:0]        mag_n, mag_s2;
	logic                 above_n, above_s2;

	assign smp = $signed({{(CW-AW){1'b0}}, sample});
	assign ctr = $signed({{(CW-FW){1'b0}}, cfg.center});
	assign gap = $signed({{(CW-FW){1'b0}}, cfg.gap});
	assign trv = $signed({{(CW-FW){1'b0}}, cfg.travel});

	assign lo = ctr - gap - trv;
	assign hi = ctr + gap + trv;

	always_comb begin
		if (smp < lo) begin
			x_c = lo;
		end else if (smp > hi) begin
			x_c = hi;
		end else begin
			x_c = smp;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= x_c;
		end
	end

	assign inner_hi = ctr + gap;
	assign inner_lo = ctr - gap;
	assign diff_hi  = x_s1 - inner_hi;
	assign diff_lo  = inner_lo - x_s1;

	// distance past the zone edge never exceeds travel, so bits [MW+1:2] hold it / 4
	always_comb begin
		if (x_s1 > inner_hi) begin
			mag_n   = diff_hi[MW+1:2];
			above_n = 1'b1;
		end else if (x_s1 < inner_lo) begin
			mag_n   = diff_lo[MW+1:2];
			above_n = 1'b0;
		end else begin
			mag_n   = '0;
			above_n = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s2   <= mag_n;
			above_s2 <= above_n;
		end
	end

	assign mag   = mag_s2;
	assign above = above_s2;

endmodule

>>> hdl/jddm_mix.sv
// Left/right mixing and gain product (stage 3), divide by 200 and byte coding.
module jddm_mix (
	input  logic                           clk,
	input  logic                           en,
	input  logic [jddm_pkg::MAG_W-1:0]     speed,
	input  logic                           rev,
	input  logic [jddm_pkg::MAG_W-1:0]     side,
	input  logic                           side_pos,
	input  logic [jddm_pkg::SCALE_W-1:0]   scale,
	output jddm_pkg::item_t                item
);

	localparam int MW = jddm_pkg::MAG_W;
	localparam int SW = jddm_pkg::MAG_W + 3;
	localparam int PW = jddm_pkg::PROD_W;
	localparam int CW = jddm_pkg::CMD_W;
	localparam int BW = jddm_pkg::BYTE_W;

	function automatic logic [CW-1:0] gain_quot(input logic [PW-1:0] prod);
		logic [jddm_pkg::SAT_W+jddm_pkg::RECIP_W-1:0] p;
		logic [CW-1:0]                                q;
		p = {{jddm_pkg::RECIP_W{1'b0}}, prod[jddm_pkg::SAT_W-1:0]}
			* {{jddm_pkg::SAT_W{1'b0}}, jddm_pkg::GAIN_RECIP};
		if (prod >= PW'(jddm_pkg::SAT_LIMIT)) begin
			q = CW'(jddm_pkg::CMD_LIMIT);
		end else begin
			q = p[jddm_pkg::GAIN_SHIFT +: CW];
		end
		return q;
	endfunction

	logic signed [SW-1:0] sp, sd, a, b, l, r;
	logic [SW-1:0]        l_abs, r_abs;
	logic [MW-1:0]        l_mag, r_mag;
	logic [PW-1:0]        prod_l_s3, prod_r_s3;
	logic                 neg_l_s3, neg_r_s3;
	logic [CW-1:0]        q_l, q_r;
	logic [BW-1:0]        q_l_ext, q_r_ext;

	assign sp = $signed({3'b000, speed});
	assign sd = side_pos ? $signed({3'b000, side}) : -$signed({3'b000, side});
	assign a  = sp + sd;
	assign b  = sp - sd;
	assign l  = rev ? -a : a;
	assign r  = rev ? -b : b;

	assign l_abs = l[SW-1] ? -l : l;
	assign r_abs = r[SW-1] ? -r : r;
	assign l_mag = (l_abs > {3'b000, speed}) ? speed : l_abs[MW-1:0];
	assign r_mag = (r_abs > {3'b000, speed}) ? speed : r_abs[MW-1:0];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_l_s3 <= {{(PW-MW){1'b0}}, l_mag} * {{(PW-jddm_pkg::SCALE_W){1'b0}}, scale};
			prod_r_s3 <= {{(PW-MW){1'b0}}, r_mag} * {{(PW-jddm_pkg::SCALE_W){1'b0}}, scale};
			neg_l_s3  <= l[SW-1];
			neg_r_s3  <= r[SW-1];
		end
	end

	assign q_l     = gain_quot(prod_l_s3);
	assign q_r     = gain_quot(prod_r_s3);
	assign q_l_ext = {{(BW-CW){1'b0}}, q_l};
	assign q_r_ext = {{(BW-CW){1'b0}}, q_r};

	assign item.byte_l = neg_l_s3 ? (jddm_pkg::LEFT_BASE - q_l_ext)
		: (jddm_pkg::LEFT_BASE + q_l_ext);
	assign item.byte_r = neg_r_s3 ? (jddm_pkg::RIGHT_BASE - q_r_ext)
		: (jddm_pkg::RIGHT_BASE + q_r_ext);
	assign item.stop   = (q_l == '0) && (q_r == '0);

endmodule

>>> hdl/jddm_out.sv
// Output stage 4: holds one coded item and sends its one or two bytes.
`include "joystick_differential_drive_mixer_top_defines.svh"
module jddm_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	input  jddm_pkg::item_t   item,
	output logic              adv,
	output logic              out_valid,
	input  logic              out_ready,
	output jddm_pkg::out_t    out_data
);

	logic            v_s4;
	jddm_pkg::item_t item_s4;
	logic            phase_q;
	logic            last;
	logic            take;

	assign last = item_s4.stop || phase_q;
	assign take = v_s4 && out_ready && last;
	assign adv  = !v_s4 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4    <= 1'b0;
			phase_q <= 1'b0;
		end else if (adv) begin
			v_s4    <= item_valid;
			phase_q <= 1'b0;
		end else if (out_ready) begin
			phase_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s4 <= item;
		end
	end

	assign out_valid = v_s4;

	always_comb begin
		if (item_s4.stop) begin
			out_data.motor_byte = jddm_pkg::BYTE_STOP;
		end else if (phase_q) begin
			out_data.motor_byte = item_s4.byte_r;
		end else begin
			out_data.motor_byte = item_s4.byte_l;
		end
		out_data.last_byte = last;
	end

	`JDDM_ASSERT_IMPL(a_phase_only_drive, clk, arst_n, phase_q, v_s4 && !item_s4.stop)
	`JDDM_ASSERT_NEXT(a_right_follows, clk, arst_n, out_valid && out_ready && !out_data.last_byte, out_valid && phase_q && $stable(item_s4))
	`JDDM_ASSERT_IMPL(a_stop_single, clk, arst_n, v_s4 && item_s4.stop, out_data.motor_byte == jddm_pkg::BYTE_STOP && out_data.last_byte)

endmodule

>>> hdl/joystick_differential_drive_mixer_top.sv
// Joystick differential drive mixer: top level with configuration registers.
//
// Input channel in_valid/in_ready carries one transaction per joystick sample
// pair (vertical, horizontal). Output channel out_valid/out_ready carries motor
// command bytes: either a single stop byte (0) or the left byte (64+left)
// followed by the right byte (192+right); last_byte marks the final one.
// Configuration is a write-only port: cfg_we, cfg_idx, cfg_wdata, taken at the
// clock edge with cfg_we high; change it only while the pipe is empty.
// Pipeline: clamp, dead zone, mix and gain product, divide and output hold:
// four register stages. An accepted sample passes them in that order before
// its first byte shows on the output.
// Throughput: one sample per cycle for stop bytes while out_ready is high; a
// drive command holds the pipe until its two bytes leave the byte-wide output.
// Reset clears all valid bits and loads the calibration defaults.
// When out_ready is low with a byte waiting, the whole pipe holds and in_ready
// drops; no transaction is lost or repeated.
module joystick_differential_drive_mixer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  jddm_pkg::in_t                     in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output jddm_pkg::out_t                    out_data,
	input  logic                              cfg_we,
	input  logic [jddm_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [jddm_pkg::CFG_W-1:0]        cfg_wdata
);

	jddm_pkg::cfg_t                 cfg_q;
	logic                           adv;
	logic                           v_s1, v_s2, v_s3;
	logic [jddm_pkg::MAG_W-1:0]     speed, side;
	logic                           v_above, h_above;
	jddm_pkg::item_t                item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vert.center  <= jddm_pkg::CENTER_RST;
			cfg_q.horiz.center <= jddm_pkg::CENTER_RST;
			cfg_q.vert.gap     <= jddm_pkg::GAP_RST;
			cfg_q.horiz.gap    <= jddm_pkg::GAP_RST;
			cfg_q.vert.travel  <= jddm_pkg::TRAVEL_RST;
			cfg_q.horiz.travel <= jddm_pkg::TRAVEL_RST;
			cfg_q.speed_scale  <= jddm_pkg::SCALE_RST;
		end else if (cfg_we) begin
			unique case (jddm_pkg::cfg_idx_t'(cfg_idx))
				jddm_pkg::CFG_VERT_CENTER:    cfg_q.vert.center  <= cfg_wdata;
				jddm_pkg::CFG_HORIZ_CENTER:   cfg_q.horiz.center <= cfg_wdata;
				jddm_pkg::CFG_VERT_DEAD_GAP:  cfg_q.vert.gap     <= cfg_wdata;
				jddm_pkg::CFG_HORIZ_DEAD_GAP: cfg_q.horiz.gap    <= cfg_wdata;
				jddm_pkg::CFG_VERT_TRAVEL:    cfg_q.vert.travel  <= cfg_wdata;
				jddm_pkg::CFG_HORIZ_TRAVEL:   cfg_q.horiz.travel <= cfg_wdata;
				jddm_pkg::CFG_SPEED_SCALE: begin
					cfg_q.speed_scale <= cfg_wdata[jddm_pkg::SCALE_W-1:0];
				end
				default: ;
			endcase
		end
	end

	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	jddm_axis u_vert (
		.clk    (clk),
		.en     (adv),
		.sample (in_data.vert_sample),
		.cfg    (cfg_q.vert),
		.mag    (speed),
		.above  (v_above)
	);

	jddm_axis u_horiz (
		.clk    (clk),
		.en     (adv),
		.sample (in_data.horiz_sample),
		.cfg    (cfg_q.horiz),
		.mag    (side),
		.above  (h_above)
	);

	jddm_mix u_mix (
		.clk      (clk),
		.en       (adv),
		.speed    (speed),
		.rev      (v_above),
		.side     (side),
		.side_pos (h_above),
		.scale    (cfg_q.speed_scale),
		.item     (item)
	);

	jddm_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s3),
		.item       (item),
		.adv        (adv),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

>>> tb/joystick_differential_drive_mixer_top_tb.sv
// Self-checking testbench of the joystick differential drive mixer: random samples, register sweeps.
module joystick_differential_drive_mixer_top_tb;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int ITEMS_PER_PHASE = 165;
	localparam int RANDOM_PHASES = 10;
	localparam int PIPE_HOLDOFF = 8;
	localparam logic [jddm_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	jddm_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	jddm_pkg::out_t out_data;
	logic cfg_we = 1'b0;
	logic [jddm_pkg::CFG_IDX_W-1:0] cfg_idx = '0;
	logic [jddm_pkg::CFG_W-1:0] cfg_wdata = '0;

	joystick_differential_drive_mixer_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	// shadow of the calibration registers
	int vcen = jddm_pkg::CENTER_RST;
	int hcen = jddm_pkg::CENTER_RST;
	int vgap = jddm_pkg::GAP_RST;
	int hgap = jddm_pkg::GAP_RST;
	int vtrv = jddm_pkg::TRAVEL_RST;
	int htrv = jddm_pkg::TRAVEL_RST;
	int gain = jddm_pkg::SCALE_RST;

	jddm_pkg::in_t pending_samples[$];
	jddm_pkg::out_t expected_bytes[$];

	int errors = 0;
	int samples_sent = 0;
	int bytes_checked = 0;
	int stops_seen = 0;
	int settings_used = 1;
	int idle_cycles = 0;
	int in_gap = 0;
	int stall_left = 0;
	bit in_idle_en = 1'b1;
	bit out_idle_en = 1'b1;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int clip(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic void mix_joystick(jddm_pkg::in_t s);
		int vs;
		int hs;
		int dir;
		int speed;
		int side;
		int lft;
		int rgt;
		jddm_pkg::out_t b;
		vs = s.vert_sample;
		hs = s.horiz_sample;
		dir = 1;
		speed = clip(vs, vcen - vgap - vtrv, vcen + vgap + vtrv);
		if (speed > vcen + vgap) begin
			speed = (speed - (vcen + vgap)) / 4;
			dir = -1;
		end else if (speed < vcen - vgap) begin
			speed = (vcen - vgap - speed) / 4;
		end else begin
			speed = 0;
		end
		side = clip(hs, hcen - hgap - htrv, hcen + hgap + htrv);
		if (side > hcen + hgap) begin
			side = (side - (hcen + hgap)) / 4;
		end else if (side < hcen - hgap) begin
			side = (side - (hcen - hgap)) / 4;
		end else begin
			side = 0;
		end
		rgt = clip(dir * (speed - side), -speed, speed);
		lft = clip(dir * (speed + side), -speed, speed);
		lft = clip(gain * lft / jddm_pkg::GAIN_DIV, -jddm_pkg::CMD_LIMIT, jddm_pkg::CMD_LIMIT);
		rgt = clip(gain * rgt / jddm_pkg::GAIN_DIV, -jddm_pkg::CMD_LIMIT, jddm_pkg::CMD_LIMIT);
		if (lft == 0 && rgt == 0) begin
			b.motor_byte = jddm_pkg::BYTE_STOP;
			b.last_byte = 1'b1;
			expected_bytes.push_back(b);
		end else begin
			b.motor_byte = 8'(int'(jddm_pkg::LEFT_BASE) + lft);
			b.last_byte = 1'b0;
			expected_bytes.push_back(b);
			b.motor_byte = 8'(int'(jddm_pkg::RIGHT_BASE) + rgt);
			b.last_byte = 1'b1;
			expected_bytes.push_back(b);
		end
	endfunction

	// one axis value: uniform, near the dead-zone edges, near the clamp bounds, or a rail
	function automatic logic [jddm_pkg::ADC_BITS-1:0] axis_value(int c, int g, int t);
		int r;
		int d;
		int v;
		r = $urandom_range(0, 9);
		d = $urandom_range(0, 12);
		d = d - 6;
		if (r < 5) begin
			v = $urandom_range(0, 1023);
		end else if (r < 7) begin
			v = ($urandom_range(0, 1) ? c + g : c - g) + d;
		end else if (r < 8) begin
			v = $urandom_range(0, 1) ? 1023 : 0;
		end else begin
			v = ($urandom_range(0, 1) ? c + g + t : c - g - t) + d;
		end
		return jddm_pkg::ADC_BITS'(clip(v, 0, 1023));
	endfunction

	function automatic jddm_pkg::in_t draw_sample();
		jddm_pkg::in_t s;
		s.vert_sample = axis_value(vcen, vgap, vtrv);
		s.horiz_sample = axis_value(hcen, hgap, htrv);
		return s;
	endfunction

	function automatic jddm_pkg::in_t mk(int v, int h);
		jddm_pkg::in_t s;
		s.vert_sample = jddm_pkg::ADC_BITS'(v);
		s.horiz_sample = jddm_pkg::ADC_BITS'(h);
		return s;
	endfunction

	task automatic set_cfg(logic [jddm_pkg::CFG_IDX_W-1:0] idx, int val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val[jddm_pkg::CFG_W-1:0];
		case (idx)
			jddm_pkg::CFG_VERT_CENTER: vcen = int'(val[jddm_pkg::CFG_W-1:0]);
			jddm_pkg::CFG_HORIZ_CENTER: hcen = int'(val[jddm_pkg::CFG_W-1:0]);
			jddm_pkg::CFG_VERT_DEAD_GAP: vgap = int'(val[jddm_pkg::CFG_W-1:0]);
			jddm_pkg::CFG_HORIZ_DEAD_GAP: hgap = int'(val[jddm_pkg::CFG_W-1:0]);
			jddm_pkg::CFG_VERT_TRAVEL: vtrv = int'(val[jddm_pkg::CFG_W-1:0]);
			jddm_pkg::CFG_HORIZ_TRAVEL: htrv = int'(val[jddm_pkg::CFG_W-1:0]);
			jddm_pkg::CFG_SPEED_SCALE: gain = int'(val[jddm_pkg::SCALE_W-1:0]);
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_samples.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (PIPE_HOLDOFF) @(posedge clk);
	endtask

	task automatic pick_config(int ph);
		case (ph)
			0: begin
				set_cfg(jddm_pkg::CFG_VERT_CENTER, 450);
				set_cfg(jddm_pkg::CFG_HORIZ_CENTER, 450);
				set_cfg(jddm_pkg::CFG_VERT_DEAD_GAP, 50);
				set_cfg(jddm_pkg::CFG_HORIZ_DEAD_GAP, 50);
				set_cfg(jddm_pkg::CFG_VERT_TRAVEL, 400);
				set_cfg(jddm_pkg::CFG_HORIZ_TRAVEL, 400);
				set_cfg(jddm_pkg::CFG_SPEED_SCALE, 100);
				set_cfg(CFG_UNUSED_IDX, 10'h2A5);
			end
			1: set_cfg(jddm_pkg::CFG_SPEED_SCALE, 0);
			2: begin
				// low bounds go negative; high bits of the gain write are dropped
				set_cfg(jddm_pkg::CFG_VERT_CENTER, 0);
				set_cfg(jddm_pkg::CFG_HORIZ_CENTER, 0);
				set_cfg(jddm_pkg::CFG_VERT_DEAD_GAP, 0);
				set_cfg(jddm_pkg::CFG_HORIZ_DEAD_GAP, 0);
				set_cfg(jddm_pkg::CFG_VERT_TRAVEL, 1023);
				set_cfg(jddm_pkg::CFG_HORIZ_TRAVEL, 1023);
				set_cfg(jddm_pkg::CFG_SPEED_SCALE, 10'h3FF);
			end
			3: begin
				set_cfg(jddm_pkg::CFG_VERT_CENTER, 1023);
				set_cfg(jddm_pkg::CFG_HORIZ_CENTER, 1023);
				set_cfg(jddm_pkg::CFG_SPEED_SCALE, 255);
			end
			4: begin
				set_cfg(jddm_pkg::CFG_VERT_DEAD_GAP, 1023);
				set_cfg(jddm_pkg::CFG_HORIZ_DEAD_GAP, 1023);
				set_cfg(jddm_pkg::CFG_VERT_TRAVEL, 0);
				set_cfg(jddm_pkg::CFG_HORIZ_TRAVEL, 0);
				set_cfg(jddm_pkg::CFG_SPEED_SCALE, 1);
			end
			default: begin
				set_cfg(jddm_pkg::CFG_VERT_CENTER, $urandom_range(0, 1023));
				set_cfg(jddm_pkg::CFG_HORIZ_CENTER, $urandom_range(0, 1023));
				set_cfg(jddm_pkg::CFG_VERT_DEAD_GAP, $urandom_range(0, 1)
					? $urandom_range(0, 120) : $urandom_range(0, 1023));
				set_cfg(jddm_pkg::CFG_HORIZ_DEAD_GAP, $urandom_range(0, 1)
					? $urandom_range(0, 120) : $urandom_range(0, 1023));
				set_cfg(jddm_pkg::CFG_VERT_TRAVEL, $urandom_range(0, 1023));
				set_cfg(jddm_pkg::CFG_HORIZ_TRAVEL, $urandom_range(0, 1023));
				set_cfg(jddm_pkg::CFG_SPEED_SCALE, $urandom_range(0, 1023));
				if ($urandom_range(0, 1))
					set_cfg(CFG_UNUSED_IDX, $urandom_range(0, 1023));
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin : drv
		logic stalled;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			in_gap <= 0;
		end else begin
			stalled = in_valid && !in_ready;
			if (in_valid && in_ready) begin
				mix_joystick(in_data);
				samples_sent++;
			end
			if (stalled) begin
			end else if (in_gap != 0) begin
				in_valid <= 1'b0;
				in_gap <= in_gap - 1;
			end else if (pending_samples.size() != 0) begin
				in_valid <= 1'b1;
				in_data <= pending_samples.pop_front();
				in_gap <= in_idle_en ? draw_gap() : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor and ready generator
	always @(posedge clk or negedge arst_n) begin : mon
		jddm_pkg::out_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected byte: expected none, actual %0d last %0b",
						$time, out_data.motor_byte, out_data.last_byte);
					errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (out_data.motor_byte !== want.motor_byte) begin
						$display("%0t: motor_byte mismatch: expected %0d, actual %0d",
							$time, want.motor_byte, out_data.motor_byte);
						errors++;
					end
					if (out_data.last_byte !== want.last_byte) begin
						$display("%0t: last_byte mismatch: expected %0b, actual %0b",
							$time, want.last_byte, out_data.last_byte);
						errors++;
					end
					if (want.motor_byte == jddm_pkg::BYTE_STOP)
						stops_seen++;
					bytes_checked++;
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (out_idle_en && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				stall_left <= draw_gap();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
		$display("%0t: watchdog expired, %0d bytes still expected", $time,
			expected_bytes.size());
		$display("joystick_differential_drive_mixer_top regression: fail");
		$finish;
	end

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed samples against the reset calibration
		pending_samples.push_back(mk(450, 450));
		pending_samples.push_back(mk(0, 450));
		pending_samples.push_back(mk(1023, 450));
		pending_samples.push_back(mk(450, 0));
		pending_samples.push_back(mk(450, 1023));
		pending_samples.push_back(mk(0, 0));
		pending_samples.push_back(mk(0, 1023));
		pending_samples.push_back(mk(1023, 0));
		pending_samples.push_back(mk(1023, 1023));
		pending_samples.push_back(mk(500, 450));
		pending_samples.push_back(mk(501, 450));
		pending_samples.push_back(mk(504, 450));
		pending_samples.push_back(mk(505, 450));
		pending_samples.push_back(mk(400, 450));
		pending_samples.push_back(mk(399, 450));
		pending_samples.push_back(mk(396, 450));
		pending_samples.push_back(mk(395, 450));
		pending_samples.push_back(mk(0, 505));
		pending_samples.push_back(mk(0, 504));
		pending_samples.push_back(mk(0, 396));
		pending_samples.push_back(mk(0, 395));
		pending_samples.push_back(mk(900, 900));
		pending_samples.push_back(mk(901, 1));
		pending_samples.push_back(mk(200, 700));

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain();
			pick_config(ph);
			in_idle_en = (ph % 4 == 0) || (ph % 4 == 2);
			out_idle_en = (ph % 4 == 0) || (ph % 4 == 1);
			repeat (ITEMS_PER_PHASE) pending_samples.push_back(draw_sample());
		end
		drain();

		$display("Covered %0d joystick samples over %0d register settings;", samples_sent,
			settings_used);
		$display("checked %0d command bytes, %0d of them stop bytes.", bytes_checked,
			stops_seen);
		if (errors == 0 && expected_bytes.size() == 0) begin
			$display("joystick_differential_drive_mixer_top regression: pass");
		end else begin
			$display("joystick_differential_drive_mixer_top regression: fail");
		end
		$finish;
	end

endmodule
